@@ rtl/tick_task_timer_table_defines.svh @@
// Assertion macros for the task timer table.
`ifndef TICK_TASK_TIMER_TABLE_DEFINES_SVH
`define TICK_TASK_TIMER_TABLE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define TTT_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define TTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ttimer_pkg.sv @@
// Types and codes shared by the task timer table.
`default_nettype none

package ttimer_pkg;

  localparam int unsigned TIDX_W = 6;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  localparam kind_t KIND_ADD      = 2'd0;
  localparam kind_t KIND_TICK     = 2'd1;
  localparam kind_t KIND_DISPATCH = 2'd2;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_NONE = 2'd2;

  typedef struct packed {
    logic [15:0] reload;
    logic [15:0] ticks;
    logic [15:0] pending;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/tick_task_timer_table.sv @@
// Task timer table: add tasks, count down on ticks, dispatch pending runs.
//
// Input channel (in_*): one beat is an add, a tick or a dispatch request.
// Result channel (out_*): exactly one beat per input beat, in order, with a
// status and a task index. Both channels use valid/stall; a stalled result
// beat holds until taken.
// Task entries live in one memory word per slot; a single 16-bit
// decrementer walks the slots in use, one slot per cycle, with the read of
// the next slot overlapped with the write-back of the current one.
// An add or an unused kind needs no walk; a tick walks every slot in use; a
// dispatch walks up to the first slot with a pending run, or over all slots
// in use if none is ready. The block takes one item at a time and in_stall is
// high until its result is loaded into the output register.
// A new beat is accepted while the previous result still waits on out_stall;
// its result then waits internally until the output register frees.
// Reset empties the table (slot count zero) and clears the output valid;
// slot memory holds no reset, since only slots below the count are read.
`default_nettype none

module tick_task_timer_table #(
  parameter int TASKS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  ttimer_pkg::kind_t                  in_kind,
  input  wire  [15:0]                        in_timeout,
  input  wire                                in_periodic,
  output logic                               out_valid,
  input  wire                                out_stall,
  output ttimer_pkg::status_t                out_status,
  output logic [ttimer_pkg::TIDX_W-1:0]      out_task_index
);

  import ttimer_pkg::*;

  `include "tick_task_timer_table_defines.svh"

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);
  localparam logic [IW-1:0] IDX_TOP = IW'(TASKS - 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic              op_tick_r, op_tick_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [IW-1:0]     res_index_r, res_index_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [TIDX_W-1:0] out_index_r, out_index_nxt;

  entry_t            mem [TASKS];
  entry_t            rdata_r;
  logic [IW-1:0]     rd_addr;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;

  logic              in_accept;
  logic              full;
  logic              last;
  logic [IW-1:0]     last_idx;
  logic [15:0]       dec_opnd;
  logic [15:0]       dec_res;
  logic [15:0]       bump_val;
  entry_t            tick_ent;

  assign in_stall       = (state_r != S_IDLE);
  assign in_accept      = in_valid && !in_stall;
  assign full           = (count_r == CW'(TASKS));
  assign last_idx       = IW'(count_r - CW'(1));
  assign last           = (idx_r == last_idx);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_task_index = out_index_r;

  assign dec_opnd = op_tick_r ? rdata_r.ticks : rdata_r.pending;
  assign dec_res  = dec_opnd - 16'd1;
  assign bump_val = (rdata_r.pending == 16'hFFFF) ? rdata_r.pending
                                                  : rdata_r.pending + 16'd1;

  always_comb begin
    tick_ent = rdata_r;
    if (rdata_r.reload != 16'd0) begin
      if (dec_res == 16'd0) begin
        tick_ent.ticks   = rdata_r.reload;
        tick_ent.pending = bump_val;
      end else begin
        tick_ent.ticks = dec_res;
      end
    end else if (rdata_r.ticks != 16'd0) begin
      tick_ent.ticks = dec_res;
      if (dec_res == 16'd0) begin
        tick_ent.pending = bump_val;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_tick_nxt    = op_tick_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    rd_addr        = '0;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = STAT_OK;
          res_index_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (in_kind) inside
            KIND_ADD: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                we            = 1'b1;
                waddr         = IW'(count_r);
                wdata.reload  = in_periodic ? in_timeout : 16'd0;
                wdata.ticks   = in_timeout;
                wdata.pending = 16'd0;
                res_index_nxt = IW'(count_r);
                count_nxt     = count_r + CW'(1);
              end
            end
            KIND_TICK, KIND_DISPATCH: begin
              op_tick_nxt = (in_kind == KIND_TICK);
              idx_nxt     = '0;
              if (count_r != '0) begin
                state_nxt = S_WALK;
              end else if (in_kind == KIND_DISPATCH) begin
                res_status_nxt = STAT_NONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        rd_addr = (idx_r == IDX_TOP) ? '0 : idx_r + 1'b1;
        if (op_tick_r) begin
          we    = 1'b1;
          wdata = tick_ent;
          if (last) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (rdata_r.pending != 16'd0) begin
          we            = 1'b1;
          wdata.pending = dec_res;
          res_index_nxt = idx_r;
          state_nxt     = S_DONE;
        end else if (last) begin
          res_status_nxt = STAT_NONE;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = TIDX_W'(res_index_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_tick_r    <= op_tick_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  `TTT_ASSERT_HOLD(a_count_bound, 1'b1, count_r <= CW'(TASKS), "task count exceeds capacity")
  `TTT_ASSERT_HOLD(a_walk_in_table, state_r == S_WALK, (count_r != '0) && (idx_r <= last_idx), "walk index outside table")
  `TTT_ASSERT_NEXT(a_done_loads_out, (state_r == S_DONE) && (!out_valid_r || !out_stall), out_valid_r && (state_r == S_IDLE), "result not handed to output")
  `TTT_ASSERT_HOLD(a_full_status, (state_r == S_DONE) && (res_status_r == STAT_FULL), count_r == CW'(TASKS), "full reported below capacity")

endmodule

`default_nettype wire

@@ tb/tick_task_timer_table_check.sv @@
// Beat monitor, schedule predictor and result comparator for the task timer table.
`timescale 1ns / 1ps

module tick_task_timer_table_check #(
  parameter int TASKS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  ttimer_pkg::kind_t               in_kind,
  input  logic [15:0]                     in_timeout,
  input  logic                            in_periodic,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  ttimer_pkg::status_t             out_status,
  input  logic [ttimer_pkg::TIDX_W-1:0]   out_task_index,
  output int                              mismatches,
  output int                              answers_owed
);

  import ttimer_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [TIDX_W-1:0]   idx;
  } task_answer_t;

  logic [15:0]  interval_q [TASKS];
  logic [15:0]  countdown_q [TASKS];
  logic [15:0]  runs_q [TASKS];
  int unsigned  used_slots;
  task_answer_t answers_due [$];

  function automatic void add_run(int unsigned slot);
    if (runs_q[slot] != 16'hFFFF) runs_q[slot] = runs_q[slot] + 16'd1;
  endfunction

  function automatic task_answer_t schedule_step(kind_t kind, logic [15:0] timeout,
                                                 logic periodic);
    task_answer_t answer;
    answer.status = STAT_OK;
    answer.idx    = '0;
    if (kind == KIND_ADD) begin
      if (used_slots < TASKS) begin
        countdown_q[used_slots] = timeout;
        runs_q[used_slots]      = 16'd0;
        interval_q[used_slots]  = periodic ? timeout : 16'd0;
        answer.idx              = TIDX_W'(used_slots);
        used_slots++;
      end else begin
        answer.status = STAT_FULL;
      end
    end else if (kind == KIND_TICK) begin
      for (int unsigned i = 0; i < used_slots; i++) begin
        if (interval_q[i] != 16'd0) begin
          countdown_q[i] = countdown_q[i] - 16'd1;
          if (countdown_q[i] == 16'd0) begin
            countdown_q[i] = interval_q[i];
            add_run(i);
          end
        end else if (countdown_q[i] != 16'd0) begin
          countdown_q[i] = countdown_q[i] - 16'd1;
          if (countdown_q[i] == 16'd0) add_run(i);
        end
      end
    end else if (kind == KIND_DISPATCH) begin
      answer.status = STAT_NONE;
      for (int unsigned i = 0; i < used_slots; i++) begin
        if (runs_q[i] != 16'd0) begin
          runs_q[i]     = runs_q[i] - 16'd1;
          answer.status = STAT_OK;
          answer.idx    = TIDX_W'(i);
          break;
        end
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin : watch
    task_answer_t due;
    task_answer_t seen;
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        interval_q[i]  = 16'd0;
        countdown_q[i] = 16'd0;
        runs_q[i]      = 16'd0;
      end
      used_slots   = 0;
      answers_due.delete();
      mismatches   = 0;
      answers_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.status = out_status;
        seen.idx    = out_task_index;
        if (answers_due.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d, task_index %0d",
                 seen.status, seen.idx);
          mismatches++;
        end else begin
          due = answers_due.pop_front();
          if (seen.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, seen.status);
            mismatches++;
          end
          if (seen.idx !== due.idx) begin
            $error("task_index: expected %0d, got %0d", due.idx, seen.idx);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(schedule_step(in_kind, in_timeout, in_periodic));
      answers_owed = answers_due.size();
    end
  end

endmodule

@@ tb/tick_task_timer_table_test.sv @@
// Stimulus, flow control and verdict for the task timer table.
`timescale 1ns / 1ps

module tick_task_timer_table_test;
  import ttimer_pkg::*;

  localparam int    TASK_SLOTS      = 16;
  localparam int    RANDOM_BEATS    = 1700;
  localparam int    TAIL_TICKS      = 200;
  localparam int    TAIL_DISPATCHES = 24;
  localparam int    QUIET_LIMIT     = 2000;
  localparam int    DRAIN_CYCLES    = 40;
  localparam kind_t KIND_SPARE      = 2'd3;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid;
  logic              in_stall;
  kind_t             in_kind;
  logic [15:0]       in_timeout;
  logic              in_periodic;
  logic              out_valid;
  logic              out_stall = 1'b0;
  status_t           out_status;
  logic [TIDX_W-1:0] out_task_index;

  int mismatches;
  int answers_owed;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  tick_task_timer_table #(
    .TASKS(TASK_SLOTS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_timeout    (in_timeout),
    .in_periodic   (in_periodic),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_task_index(out_task_index)
  );

  tick_task_timer_table_check #(
    .TASKS(TASK_SLOTS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_timeout    (in_timeout),
    .in_periodic   (in_periodic),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_task_index(out_task_index),
    .mismatches    (mismatches),
    .answers_owed  (answers_owed)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(negedge clk) begin
    if (stall_left == 0 && out_idle_on && rst_n && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 16);
    out_stall = (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_beat(input kind_t kind, input logic [15:0] timeout, input logic periodic);
    int gap;
    gap = 0;
    if (in_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_kind     = kind;
    in_timeout  = timeout;
    in_periodic = periodic;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int          served;
    int          pick;
    kind_t       kind;
    logic [15:0] timeout;
    logic        periodic;

    in_valid    = 1'b0;
    in_kind     = KIND_TICK;
    in_timeout  = 16'd0;
    in_periodic = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(KIND_DISPATCH, 16'hFFFF, 1'b1);
    send_beat(KIND_TICK, 16'd0, 1'b0);
    send_beat(KIND_SPARE, 16'h5A5A, 1'b1);
    send_beat(KIND_ADD, 16'd1, 1'b0);
    send_beat(KIND_ADD, 16'd0, 1'b1);
    send_beat(KIND_ADD, 16'd2, 1'b1);
    send_beat(KIND_ADD, 16'hFFFF, 1'b1);
    send_beat(KIND_ADD, 16'd0, 1'b0);
    repeat (3) send_beat(KIND_TICK, 16'hA5A5, 1'b1);
    repeat (4) send_beat(KIND_DISPATCH, 16'd0, 1'b0);
    send_beat(KIND_SPARE, 16'd0, 1'b0);
    send_beat(KIND_TICK, 16'd0, 1'b0);
    send_beat(KIND_DISPATCH, 16'd0, 1'b0);

    served = 0;
    while (served < RANDOM_BEATS) begin
      if ($urandom_range(0, 149) == 0) begin
        in_idle_on  = ($urandom_range(0, 2) != 0);
        out_idle_on = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12)      kind = KIND_ADD;
      else if (pick < 52) kind = KIND_TICK;
      else if (pick < 95) kind = KIND_DISPATCH;
      else                kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 10)      timeout = 16'd0;
      else if (pick < 80) timeout = 16'($urandom_range(1, 12));
      else if (pick < 90) timeout = 16'($urandom_range(13, 300));
      else                timeout = 16'($urandom);
      periodic = 1'($urandom_range(0, 1));
      send_beat(kind, timeout, periodic);
      served++;
    end

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (TAIL_TICKS) send_beat(KIND_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
    repeat (TAIL_DISPATCHES) send_beat(KIND_DISPATCH, 16'($urandom), 1'($urandom_range(0, 1)));
    in_valid = 1'b0;

    wait (answers_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && answers_owed == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
